// ----- src/event_activity_map_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the event activity map.
// Checks are sampled on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EVENT_ACTIVITY_MAP_MACROS_SVH
`define EVENT_ACTIVITY_MAP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define EAM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("event_activity_map: same-cycle check failed");
`define EAM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("event_activity_map: next-cycle check failed");
`else
`define EAM_ASSERT_IMP(label, ante, cons)
`define EAM_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- src/eam_pkg.sv -----
// ----------------------------------------------------------------------------
// eam_pkg
// Shared constants, codes and types of the event activity map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eam_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int EH_W       = $clog2(MAX_HEIGHT + 1);

    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int COORD_W    = 10;
    localparam int CMP_W      = 11;
    localparam int GEOM_W     = 9;
    localparam int INC_W      = 17;
    localparam int FACTOR_W   = 16;
    localparam int VALUE_W    = 16;
    localparam int SUM_W      = 18;
    localparam int PROD_W     = VALUE_W + FACTOR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 16'd65280;
    localparam logic [VALUE_W-1:0] ONE_Q88   = 16'd256;

    localparam logic [GEOM_W-1:0]   RST_FRAME_WIDTH  = 9'd128;
    localparam logic [GEOM_W-1:0]   RST_FRAME_HEIGHT = 9'd128;
    localparam logic [INC_W-1:0]    RST_ON_INC       = 17'd256;
    localparam logic [INC_W-1:0]    RST_OFF_INC      = 17'd256;
    localparam logic [FACTOR_W-1:0] RST_DECAY_FACTOR = 16'd58982;

    typedef enum logic [OP_W-1:0] {
        OP_DECAY = 2'd0,
        OP_EVENT = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED    = 2'd0,
        ST_DROPPED    = 2'd1,
        ST_DECAY_DONE = 2'd2,
        ST_READ_DATA  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_ON_INC       = 3'd2,
        CFG_OFF_INC      = 3'd3,
        CFG_DECAY_FACTOR = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_READ,
        S_MODIFY,
        S_DECAY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [EW_W-1:0]            eff_width;
        logic [EH_W-1:0]            eff_height;
        logic signed [INC_W-1:0]    on_inc;
        logic signed [INC_W-1:0]    off_inc;
        logic [FACTOR_W-1:0]        decay_factor;
    } t_cfg;

endpackage

// ----- src/eam_ram.sv -----
// ----------------------------------------------------------------------------
// eam_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/eam_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// eam_cfg_regs
// Configuration registers with the effective frame geometry derived from them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eam_cfg_regs
    import eam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [GEOM_W-1:0]   r_frame_width;
    logic [GEOM_W-1:0]   r_frame_height;
    logic [INC_W-1:0]    r_on_inc;
    logic [INC_W-1:0]    r_off_inc;
    logic [FACTOR_W-1:0] r_decay_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_on_inc       <= RST_ON_INC;
            r_off_inc      <= RST_OFF_INC;
            r_decay_factor <= RST_DECAY_FACTOR;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[GEOM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[GEOM_W-1:0];
                CFG_ON_INC:       r_on_inc       <= i_cfg_data[INC_W-1:0];
                CFG_OFF_INC:      r_off_inc      <= i_cfg_data[INC_W-1:0];
                CFG_DECAY_FACTOR: r_decay_factor <= i_cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.eff_width = (CMP_W'(r_frame_width) > CMP_W'(MAX_WIDTH))
                        ? EW_W'(MAX_WIDTH) : EW_W'(r_frame_width);
        o_cfg.eff_height = (CMP_W'(r_frame_height) > CMP_W'(MAX_HEIGHT))
                         ? EH_W'(MAX_HEIGHT) : EH_W'(r_frame_height);
        o_cfg.on_inc       = $signed(r_on_inc);
        o_cfg.off_inc      = $signed(r_off_inc);
        o_cfg.decay_factor = r_decay_factor;
    end

endmodule

// ----- src/eam_update.sv -----
// ----------------------------------------------------------------------------
// eam_update
// Pixel arithmetic: Q0.16 decay that zeroes values below 1.0, and saturating event add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eam_update
    import eam_pkg::*;
(
    input  logic [VALUE_W-1:0]     i_old,
    input  logic [FACTOR_W-1:0]    i_factor,
    input  logic signed [INC_W-1:0] i_inc,
    output logic [VALUE_W-1:0]     o_decayed,
    output logic [VALUE_W-1:0]     o_summed
);

    logic [PROD_W-1:0]       prod;
    logic [VALUE_W-1:0]      scaled;
    logic signed [SUM_W-1:0] sum;

    always_comb begin
        prod      = PROD_W'(i_old) * PROD_W'(i_factor);
        scaled    = prod[PROD_W-1:FACTOR_W];
        o_decayed = (scaled < ONE_Q88) ? '0 : scaled;

        sum = $signed({2'b00, i_old}) + $signed({i_inc[INC_W-1], i_inc});
        if (sum[SUM_W-1]) begin
            o_summed = '0;
        end else if (sum > $signed({2'b00, VALUE_MAX})) begin
            o_summed = VALUE_MAX;
        end else begin
            o_summed = sum[VALUE_W-1:0];
        end
    end

endmodule

// ----- src/event_activity_map.sv -----
// ----------------------------------------------------------------------------
// event_activity_map
// Per-pixel decaying activity map for an event camera, held in one RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole map to zero, one entry per cycle, and
// accepts no transaction until all MAP_DEPTH entries are cleared;
// configuration writes are taken during that time. Items are handled one at
// a time through a read-modify-write on the map RAM: the index calculation,
// the RAM read and the update, and the next transaction is accepted in the
// idle state after the result is loaded. An item that falls outside the frame
// or carries the unused opcode skips the RAM read and goes from the index
// calculation straight to its result. A decay pass streams the effective
// width * height entries through the decay multiplier, reading one entry and
// writing back the previous one each cycle. A finished result waits in its
// state while the output register is full and not taken. Results sit in an
// output register, so a new transaction is accepted while the previous result
// waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "event_activity_map_macros.svh"

module event_activity_map
    import eam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [COORD_W-1:0]    i_x_coord,
    input  logic [COORD_W-1:0]    i_y_coord,
    input  logic                  i_polarity,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [VALUE_W-1:0]    o_activity_value
);

    t_cfg                 cfg;
    t_state               r_state;
    t_state               n_state;
    t_opcode              r_op;
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_y;
    logic                 r_pol;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_clr_cnt;
    logic [CNT_W-1:0]     r_rd_cnt;
    logic [CNT_W-1:0]     r_limit;
    logic                 r_dv;
    logic [ADDR_W-1:0]    r_dv_addr;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [VALUE_W-1:0]   r_out_value;

    logic                 in_frame;
    logic [CNT_W-1:0]     index_full;
    logic [CNT_W-1:0]     limit_calc;
    logic                 out_free;
    logic                 load_out;
    logic                 decay_rd;
    t_status              res_status;
    logic [VALUE_W-1:0]   res_value;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic signed [INC_W-1:0] inc_sel;
    logic [VALUE_W-1:0]   decayed;
    logic [VALUE_W-1:0]   summed;

    eam_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    eam_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign inc_sel = r_pol ? cfg.on_inc : cfg.off_inc;

    eam_update u_update (
        .i_old     (ram_rdata),
        .i_factor  (cfg.decay_factor),
        .i_inc     (inc_sel),
        .o_decayed (decayed),
        .o_summed  (summed)
    );

    assign in_frame   = (CMP_W'(r_x) < CMP_W'(cfg.eff_width))
                     && (CMP_W'(r_y) < CMP_W'(cfg.eff_height));
    assign index_full = CNT_W'(r_y) * CNT_W'(cfg.eff_width) + CNT_W'(r_x);
    assign limit_calc = CNT_W'(cfg.eff_width) * CNT_W'(cfg.eff_height);
    assign out_free   = !r_out_valid || i_out_ready;
    assign decay_rd   = (r_state == S_DECAY) && (r_rd_cnt < r_limit);

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        res_status = ST_DROPPED;
        res_value  = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = summed;
        ram_re     = 1'b0;
        ram_raddr  = r_addr;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                ram_wdata = '0;
                if (r_clr_cnt == ADDR_W'(MAP_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: begin
                if (r_op == OP_DECAY) begin
                    n_state = S_DECAY;
                end else if (r_op == OP_NONE || !in_frame) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                if (r_op == OP_READ) begin
                    res_status = ST_READ_DATA;
                    res_value  = ram_rdata;
                end else begin
                    res_status = ST_APPLIED;
                    res_value  = summed;
                end
                if (out_free) begin
                    load_out = 1'b1;
                    ram_we   = (r_op == OP_EVENT);
                    n_state  = S_IDLE;
                end
            end
            S_DECAY: begin
                ram_re    = decay_rd;
                ram_raddr = r_rd_cnt[ADDR_W-1:0];
                ram_we    = r_dv;
                ram_waddr = r_dv_addr;
                ram_wdata = decayed;
                if (!decay_rd && !r_dv) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                res_status = (r_op == OP_DECAY) ? ST_DECAY_DONE : ST_DROPPED;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_rd_cnt    <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (r_state == S_INDEX) begin
                r_rd_cnt <= '0;
                r_dv     <= 1'b0;
            end else if (r_state == S_DECAY) begin
                r_dv <= decay_rd;
                if (decay_rd) begin
                    r_rd_cnt <= r_rd_cnt + 1'b1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op  <= t_opcode'(i_opcode);
            r_x   <= i_x_coord;
            r_y   <= i_y_coord;
            r_pol <= i_polarity;
        end
        if (r_state == S_INDEX) begin
            r_addr  <= index_full[ADDR_W-1:0];
            r_limit <= limit_calc;
        end
        if (decay_rd) begin
            r_dv_addr <= r_rd_cnt[ADDR_W-1:0];
        end
        if (load_out) begin
            r_out_status <= res_status;
            r_out_value  <= res_value;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_activity_value = r_out_value;

    `EAM_ASSERT_IMP(a_decay_wr_in_range, r_dv, CNT_W'(r_dv_addr) < r_limit)
    `EAM_ASSERT_IMP(a_no_rw_same_entry, ram_we && ram_re, ram_waddr != ram_raddr)
    `EAM_ASSERT_IMP(a_value_capped, o_out_valid, o_activity_value <= VALUE_MAX)
    `EAM_ASSERT_NXT(a_accept_to_index, i_in_valid && o_in_ready, r_state == S_INDEX)

endmodule

// ----- dv/event_activity_map_checker.sv -----
// ----------------------------------------------------------------------------
// event_activity_map_checker
// Watches the configuration port and both channels of the activity map,
// keeps its own copy of the pixel store and registers, works out the result
// of every accepted transaction and compares each returned result with the
// oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module event_activity_map_checker
    import eam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [COORD_W-1:0]    i_x_coord,
    input  logic [COORD_W-1:0]    i_y_coord,
    input  logic                  i_polarity,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [VALUE_W-1:0]    i_activity_value,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] value;
    } t_pixel_result;

    logic [VALUE_W-1:0]      pixel_store [MAP_DEPTH];
    logic [GEOM_W-1:0]       frame_width;
    logic [GEOM_W-1:0]       frame_height;
    logic signed [INC_W-1:0] on_step;
    logic signed [INC_W-1:0] off_step;
    logic [FACTOR_W-1:0]     fade_factor;
    t_pixel_result           owed_results [$];
    int                      mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int unsigned clip_geometry(logic [GEOM_W-1:0] dim, int unsigned limit);
        return (dim > limit) ? limit : dim;
    endfunction

    function automatic t_pixel_result update_activity(logic [OP_W-1:0] op,
            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic pol);
        t_pixel_result           res;
        int unsigned             w;
        int unsigned             h;
        int unsigned             idx;
        int                      sum;
        logic signed [INC_W-1:0] step;
        logic [PROD_W-1:0]       prod;
        res.status = ST_DROPPED;
        res.value  = '0;
        w = clip_geometry(frame_width, MAX_WIDTH);
        h = clip_geometry(frame_height, MAX_HEIGHT);
        if (op == OP_DECAY) begin
            for (int unsigned i = 0; i < w * h; i++) begin
                prod = pixel_store[ADDR_W'(i)] * fade_factor;
                pixel_store[ADDR_W'(i)] = (prod[PROD_W-1:FACTOR_W] < ONE_Q88) ? '0 :
                                          prod[PROD_W-1:FACTOR_W];
            end
            res.status = ST_DECAY_DONE;
        end else if (op != OP_NONE && x < w && y < h) begin
            idx = y * w + x;
            if (op == OP_READ) begin
                res.status = ST_READ_DATA;
                res.value  = pixel_store[ADDR_W'(idx)];
            end else begin
                step = pol ? on_step : off_step;
                sum  = int'(pixel_store[ADDR_W'(idx)]) + int'(step);
                if (sum < 0) begin
                    sum = 0;
                end
                if (sum > int'(VALUE_MAX)) begin
                    sum = int'(VALUE_MAX);
                end
                pixel_store[ADDR_W'(idx)] = VALUE_W'(sum);
                res.status = ST_APPLIED;
                res.value  = VALUE_W'(sum);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            foreach (pixel_store[i]) pixel_store[i] = '0;
            frame_width  = RST_FRAME_WIDTH;
            frame_height = RST_FRAME_HEIGHT;
            on_step      = RST_ON_INC;
            off_step     = RST_OFF_INC;
            fade_factor  = RST_DECAY_FACTOR;
            owed_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  frame_width  = i_cfg_data[GEOM_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height = i_cfg_data[GEOM_W-1:0];
                    CFG_ON_INC:       on_step      = i_cfg_data[INC_W-1:0];
                    CFG_OFF_INC:      off_step     = i_cfg_data[INC_W-1:0];
                    CFG_DECAY_FACTOR: fade_factor  = i_cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(update_activity(i_opcode, i_x_coord, i_y_coord,
                                                       i_polarity));
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result status %0d value %0d with nothing owed",
                                              i_status, i_activity_value));
                end else begin
                    want = owed_results.pop_front();
                    if (i_status != want.status) begin
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  i_status, want.status.name()));
                    end
                    if (i_activity_value != want.value) begin
                        report_mismatch($sformatf("activity value %0d, expected %0d",
                                                  i_activity_value, want.value));
                    end
                end
            end
            o_pending <= owed_results.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the event activity map. A short directed part
// covers reset values, frame edges, saturation at both ends, decay zeroing,
// zero and oversize geometry and the unused opcode; then random phases with
// fresh register settings drive events, reads and decay passes with random
// gaps and output stalls, including one long output hold-off. Checking is
// done by the checker module alongside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import eam_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int FULL_FRAME_PHASE = 2;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DECAY_AREA_MAX  = 1024;
    localparam int STALL_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 20;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode = '0;
    logic [COORD_W-1:0]    x_coord = '0;
    logic [COORD_W-1:0]    y_coord = '0;
    logic                  polarity = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [VALUE_W-1:0]    activity_value;
    int                    fail_count;
    int                    pending;

    int idle_odds = 4;
    int stall_odds = 5;
    bit hold_off_req = 1'b0;
    int op_count [4] = '{0, 0, 0, 0};
    int cfg_sets = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    event_activity_map i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_x_coord        (x_coord),
        .i_y_coord        (y_coord),
        .i_polarity       (polarity),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_activity_value (activity_value)
    );

    event_activity_map_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_x_coord        (x_coord),
        .i_y_coord        (y_coord),
        .i_polarity       (polarity),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_activity_value (activity_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [GEOM_W-1:0] w, input logic [GEOM_W-1:0] h,
            input logic [INC_W-1:0] on_inc, input logic [INC_W-1:0] off_inc,
            input logic [FACTOR_W-1:0] factor);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_ON_INC, on_inc);
        write_reg(CFG_OFF_INC, off_inc);
        write_reg(CFG_DECAY_FACTOR, CFG_DATA_W'(factor));
        cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    task automatic send_item(input t_opcode op, input logic [COORD_W-1:0] x,
            input logic [COORD_W-1:0] y, input logic pol);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        x_coord  <= x;
        y_coord  <= y;
        polarity <= pol;
        do @(posedge clk); while (!in_ready);
        op_count[op]++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random(input int w, input int h, input bit allow_decay);
        int                 r;
        t_opcode            op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        r = $urandom_range(0, 99);
        if (allow_decay && r < 4) begin
            op = OP_DECAY;
        end else if (r < 9) begin
            op = OP_NONE;
        end else if (r < 35) begin
            op = OP_READ;
        end else begin
            op = OP_EVENT;
        end
        if (w == 0 || h == 0 || $urandom_range(0, 9) == 0) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end else if ($urandom_range(0, 2) == 0) begin
            // A small cluster of pixels so that values build up to saturation.
            x = COORD_W'($urandom_range(0, ((w < 4) ? w : 4) - 1));
            y = COORD_W'($urandom_range(0, ((h < 4) ? h : 4) - 1));
        end else begin
            x = COORD_W'($urandom_range(0, w - 1));
            y = COORD_W'($urandom_range(0, h - 1));
        end
        send_item(op, x, y, 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [INC_W-1:0] pick_increment();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 131071);
            1: v = $urandom_range(1, 4096);
            2: v = -int'($urandom_range(1, 4096));
            default: v = $urandom_range(0, 1) ? int'(VALUE_MAX) : -int'(VALUE_MAX);
        endcase
        return INC_W'(v);
    endfunction

    function automatic logic [FACTOR_W-1:0] pick_factor();
        case ($urandom_range(0, 2))
            0: return FACTOR_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return FACTOR_W'($urandom_range(40000, 65535));
        endcase
    endfunction

    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t ERROR: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int w;
        int h;
        int ew;
        int eh;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values and a cleared store.
        send_item(OP_READ, 10'd0, 10'd0, 1'b0);
        send_item(OP_EVENT, 10'd0, 10'd0, 1'b1);
        send_item(OP_EVENT, 10'd0, 10'd0, 1'b0);
        send_item(OP_EVENT, 10'd127, 10'd127, 1'b1);
        send_item(OP_EVENT, 10'd128, 10'd0, 1'b1);
        send_item(OP_EVENT, 10'd0, 10'd128, 1'b0);
        send_item(OP_EVENT, 10'd1023, 10'd1023, 1'b1);
        send_item(OP_READ, 10'd1023, 10'd0, 1'b0);
        send_item(OP_NONE, 10'd5, 10'd5, 1'b1);
        send_item(OP_DECAY, 10'd0, 10'd0, 1'b0);
        send_item(OP_READ, 10'd0, 10'd0, 1'b0);
        send_item(OP_READ, 10'd127, 10'd127, 1'b1);
        wait_idle();

        // Oversize width, nominal increment limits, full decay factor.
        apply_config(9'd511, 9'd1, 17'(VALUE_MAX), 17'(-int'(VALUE_MAX)), 16'hFFFF);
        send_item(OP_EVENT, 10'd255, 10'd0, 1'b1);
        send_item(OP_EVENT, 10'd255, 10'd0, 1'b1);
        send_item(OP_DECAY, 10'd0, 10'd0, 1'b0);
        send_item(OP_EVENT, 10'd255, 10'd0, 1'b0);
        send_item(OP_EVENT, 10'd255, 10'd0, 1'b0);
        send_item(OP_EVENT, 10'd256, 10'd0, 1'b1);
        send_item(OP_READ, 10'd0, 10'd1, 1'b0);
        send_item(OP_READ, 10'd255, 10'd0, 1'b0);
        wait_idle();

        // Zero width: nothing in frame, decay still completes.
        apply_config(9'd0, 9'd511, 17'h0FFFF, 17'h10000, 16'h0000);
        send_item(OP_EVENT, 10'd0, 10'd0, 1'b1);
        send_item(OP_READ, 10'd0, 10'd0, 1'b0);
        send_item(OP_DECAY, 10'd0, 10'd0, 1'b0);
        wait_idle();

        // Increments beyond the nominal range and a zero decay factor.
        apply_config(9'd2, 9'd2, 17'h0FFFF, 17'h10000, 16'h0000);
        send_item(OP_EVENT, 10'd1, 10'd1, 1'b1);
        send_item(OP_DECAY, 10'd0, 10'd0, 1'b0);
        send_item(OP_READ, 10'd1, 10'd1, 1'b0);
        send_item(OP_EVENT, 10'd1, 10'd1, 1'b0);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 24);
                end
                1: begin
                    w = $urandom_range(256, 511);
                    h = $urandom_range(1, 2);
                end
                2: begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(256, 511);
                end
                default: begin
                    w = $urandom_range(1, 511);
                    h = $urandom_range(1, 511);
                end
            endcase
            if (ph == FULL_FRAME_PHASE) begin
                w = MAX_WIDTH;
                h = MAX_HEIGHT;
            end
            apply_config(GEOM_W'(w), GEOM_W'(h), pick_increment(), pick_increment(),
                         pick_factor());
            ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
            eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
            if (ph == RANDOM_PHASES - 1) begin
                idle_odds  = 0;
                stall_odds = 0;
            end else begin
                idle_odds  = $urandom_range(0, 1) ? 4 : 0;
                stall_odds = $urandom_range(0, 1) ? 5 : 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 0 && n == 60) begin
                    hold_off_req = 1'b1;
                end
                if (ph == FULL_FRAME_PHASE && n == ITEMS_PER_PHASE / 2) begin
                    send_item(OP_DECAY, 10'd0, 10'd0, 1'b0);
                end else begin
                    send_random(ew, eh, (ew * eh) <= DECAY_AREA_MAX);
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d events, %0d reads, %0d decay passes and %0d unused opcodes",
                 op_count[OP_EVENT], op_count[OP_READ], op_count[OP_DECAY],
                 op_count[OP_NONE]);
        $display("over %0d register settings, from empty and single-row frames to full size",
                 cfg_sets + 1);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
